### hw/rtl/ptwbl_pkg.sv
`default_nettype none

package ptwbl_pkg;

    // Table size and configuration port shape.
    localparam int TableEntriesDefault = 16;
    localparam int CfgAddrWidth        = 2;
    localparam int CfgDataWidth        = 32;

    // Register indexes on the configuration port.
    localparam logic [CfgAddrWidth-1:0] REG_BUFFER_LIMIT = 2'd0;
    localparam logic [CfgAddrWidth-1:0] REG_HEADER_BYTES = 2'd1;
    localparam logic [CfgAddrWidth-1:0] REG_TIME_LIMIT   = 2'd2;

    // Register reset values.
    localparam logic [15:0] BUFFER_LIMIT_RESET = 16'd2048;
    localparam logic [7:0]  HEADER_BYTES_RESET = 8'd16;
    localparam logic [31:0] TIME_LIMIT_RESET   = 32'd100000;

    // Result status codes.
    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_TOO_LATE = 2'd1;
    localparam logic [1:0] ST_BUF_FULL = 2'd2;
    localparam logic [1:0] ST_TAB_FULL = 2'd3;

    // Header under lookup, broadcast to every cell.
    typedef struct packed {
        logic [31:0] msg_type;
        logic [31:0] msg_time;
        logic [31:0] msg_len;
        logic        late;
    } item_t;

    // Limits that the cells need for the buffer check.
    typedef struct packed {
        logic [15:0] buffer_limit;
        logic [7:0]  header_bytes;
    } limits_t;

    // Result reported by the cell that resolves the header.
    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic [31:0] msg_count;
        logic [31:0] second_count;
    } cell_res_t;

    // Increment that sticks at the all-ones value.
    function automatic logic [31:0] sat_inc(input logic [31:0] value);
        logic [31:0] result;
        result = (value == 32'hFFFF_FFFF) ? value : value + 32'd1;
        return result;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/per_type_window_byte_limiter.sv
`default_nettype none

// Channel   | Ports            | Contents
// ----------+------------------+---------------------------------------------
// input     | s_tvalid/tready  | s_tdata: msg_type, msg_time, msg_len
// result    | m_tvalid/tready  | m_tdata: type_msg_count, type_second_count;
//           |                  | m_tuser: status
// config    | cfg_we           | cfg_addr selects register, cfg_wdata value
//
// One item is in the table at a time. After acceptance a probe walks the row
// of entry cells, one cell per cycle, and stops at the matching or first free
// entry; the result is registered when the probe stops or runs off the row.
// A new item is taken as soon as the previous result is in the output
// register. A stalled result freezes the walk. Reset clears the entry valid
// bits and restores the register defaults.
module per_type_window_byte_limiter
    import ptwbl_pkg::*;
#(
    parameter int TABLE_ENTRIES = TableEntriesDefault
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // Input item: [31:0] msg_type, [63:32] msg_time, [95:64] msg_len.
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [95:0]             s_tdata,
    // Result item: [31:0] type_msg_count, [63:32] type_second_count.
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [63:0]                  m_tdata,
    // Result kind: [1:0] status.
    output logic [1:0]                   m_tuser,
    // Configuration writes.
    input  wire logic                    cfg_we,
    input  wire logic [CfgAddrWidth-1:0] cfg_addr,
    input  wire logic [CfgDataWidth-1:0] cfg_wdata
);

    logic [15:0] buffer_limit_reg;
    logic [7:0]  header_bytes_reg;
    logic [31:0] time_limit_reg;

    logic        busy_reg;
    logic        start_reg;
    item_t       item_reg;
    logic        m_tvalid_reg;
    logic [1:0]  status_reg;
    logic [31:0] msg_count_reg;
    logic [31:0] second_count_reg;

    logic        accept;
    logic        advance;
    logic        miss;
    limits_t     limits;
    cell_res_t   res_any;

    logic      [TABLE_ENTRIES:0]   probe;
    cell_res_t                     cell_res [TABLE_ENTRIES];

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && !busy_reg;
    assign advance  = !m_tvalid_reg || m_tready;

    assign limits.buffer_limit = buffer_limit_reg;
    assign limits.header_bytes = header_bytes_reg;

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {second_count_reg, msg_count_reg};

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buffer_limit_reg <= BUFFER_LIMIT_RESET;
            header_bytes_reg <= HEADER_BYTES_RESET;
            time_limit_reg   <= TIME_LIMIT_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_BUFFER_LIMIT: buffer_limit_reg <= cfg_wdata[15:0];
                REG_HEADER_BYTES: header_bytes_reg <= cfg_wdata[7:0];
                REG_TIME_LIMIT:   time_limit_reg   <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // Header capture; the late check is settled on the way in.
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.msg_type <= s_tdata[31:0];
            item_reg.msg_time <= s_tdata[63:32];
            item_reg.msg_len  <= s_tdata[95:64];
            item_reg.late     <= s_tdata[63:32] > time_limit_reg;
        end
    end

    // Row of entry cells.
    assign probe[0] = start_reg;

    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
        ptwbl_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .probe_in  (probe[i]),
            .item      (item_reg),
            .limits    (limits),
            .probe_out (probe[i+1]),
            .res       (cell_res[i])
        );
    end

    // At most one cell reports at a time, so the results merge by OR.
    always_comb begin
        res_any = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            res_any = res_any | cell_res[i];
        end
    end

    assign miss = probe[TABLE_ENTRIES];

    // Sequencing and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            start_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                busy_reg  <= 1'b1;
                start_reg <= 1'b1;
            end else if (advance) begin
                start_reg <= 1'b0;
            end
            if (advance && (res_any.valid || miss)) begin
                busy_reg     <= 1'b0;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result payload: a probe that runs off the end of the row found no room.
    always_ff @(posedge aclk) begin
        if (advance && res_any.valid) begin
            status_reg       <= res_any.status;
            msg_count_reg    <= res_any.msg_count;
            second_count_reg <= res_any.second_count;
        end else if (advance && miss) begin
            status_reg       <= item_reg.late ? ST_TOO_LATE : ST_TAB_FULL;
            msg_count_reg    <= 32'd0;
            second_count_reg <= 32'd0;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ptwbl_cell.sv
`default_nettype none

// One table entry. A probe bit enters from the left neighbor; the cell either
// resolves the header (matching key or free entry) or hands the probe on.
module ptwbl_cell
    import ptwbl_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      advance,
    input  wire logic      probe_in,
    input  wire item_t     item,
    input  wire limits_t   limits,
    output logic           probe_out,
    output cell_res_t      res
);

    logic        valid_reg;
    logic        probe_reg;
    logic [31:0] key_reg;
    logic [31:0] acc_reg;
    logic [31:0] sec_reg;
    logic [31:0] last_reg;
    logic [15:0] used_reg;

    logic        hit;
    logic        take;
    logic        resolve;
    logic        update;
    logic [31:0] base_acc;
    logic [31:0] base_sec;
    logic [31:0] base_last;
    logic [15:0] base_used;
    logic        new_second;
    logic [31:0] sec_next;
    logic [15:0] used_mid;
    logic [33:0] need;
    logic        buf_full;
    logic [31:0] acc_next;
    logic [15:0] used_next;

    // Lookup: the probe stops at the matching entry or the first free one.
    assign hit       = valid_reg && (key_reg == item.msg_type);
    assign take      = !valid_reg;
    assign resolve   = hit || take;
    assign probe_out = probe_reg && !resolve;
    assign update    = advance && probe_reg && resolve && !item.late;

    // Counts as seen by this header, with a freshly taken entry zeroed.
    always_comb begin
        base_acc   = take ? 32'd0 : acc_reg;
        base_sec   = take ? 32'd0 : sec_reg;
        base_last  = take ? 32'd0 : last_reg;
        base_used  = take ? 16'd0 : used_reg;
        new_second = (base_last != item.msg_time);
        sec_next   = new_second ? sat_inc(base_sec) : base_sec;
        used_mid   = new_second ? 16'd0 : base_used;
        need       = {18'd0, used_mid} + {2'd0, item.msg_len} + {26'd0, limits.header_bytes};
        buf_full   = need > {18'd0, limits.buffer_limit};
        acc_next   = buf_full ? base_acc : sat_inc(base_acc);
        used_next  = buf_full ? used_mid : used_mid + item.msg_len[15:0];
    end

    // Report the outcome while the probe sits here.
    always_comb begin
        res = '0;
        if (probe_reg && resolve) begin
            res.valid = 1'b1;
            if (item.late) begin
                res.status       = ST_TOO_LATE;
                res.msg_count    = hit ? acc_reg : 32'd0;
                res.second_count = hit ? sec_reg : 32'd0;
            end else begin
                res.status       = buf_full ? ST_BUF_FULL : ST_ACCEPTED;
                res.msg_count    = acc_next;
                res.second_count = sec_next;
            end
        end
    end

    // Control state: entry in use and probe position.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            probe_reg <= 1'b0;
        end else begin
            if (advance) begin
                probe_reg <= probe_in;
            end
            if (update) begin
                valid_reg <= 1'b1;
            end
        end
    end

    // Entry payload.
    always_ff @(posedge aclk) begin
        if (update) begin
            key_reg  <= item.msg_type;
            acc_reg  <= acc_next;
            sec_reg  <= sec_next;
            last_reg <= item.msg_time;
            used_reg <= used_next;
        end
    end

endmodule

`default_nettype wire

### tb/per_type_window_byte_limiter_tb.sv
`timescale 1ns / 100ps

module per_type_window_byte_limiter_tb;
    import ptwbl_pkg::*;

    localparam int ENTRIES       = 16;
    localparam int CLK_HALF      = 4;
    localparam int MAX_WAIT      = 11;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int REPORT_CAP    = 50;

    // The port has one index past the last register; writes there are ignored.
    localparam logic [CfgAddrWidth-1:0] REG_UNUSED = 2'd3;

    // One message header, msg_type in the lowest bits.
    typedef struct packed {
        logic [31:0] msg_len;
        logic [31:0] msg_time;
        logic [31:0] msg_type;
    } header_t;

    // What the block should report for one header.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] msg_count;
        logic [31:0] second_count;
    } verdict_t;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    // Fields from bit 0 up: msg_type, msg_time, msg_len.
    logic [95:0]             s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    // Fields from bit 0 up: type_msg_count, type_second_count.
    logic [63:0]             m_tdata;
    // Fields from bit 0 up: status.
    logic [1:0]              m_tuser;
    logic                    cfg_we;
    logic [CfgAddrWidth-1:0] cfg_addr;
    logic [CfgDataWidth-1:0] cfg_wdata;

    per_type_window_byte_limiter #(
        .TABLE_ENTRIES(ENTRIES)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    // Our own copy of the limits and of the per-type table.
    logic [15:0] lim_buffer;
    logic [7:0]  lim_header;
    logic [31:0] lim_time;
    bit          slot_valid  [ENTRIES];
    logic [31:0] slot_key    [ENTRIES];
    logic [31:0] slot_msgs   [ENTRIES];
    logic [31:0] slot_secs   [ENTRIES];
    logic [31:0] slot_second [ENTRIES];
    logic [15:0] slot_bytes  [ENTRIES];

    verdict_t    pending_verdicts[$];
    bit [31:0]   known_types[ENTRIES];
    logic [31:0] now_sec;
    int          mismatches;
    int          checked;
    int          sent;
    int          cycle_count;
    int          status_seen[4];
    bit          src_idle;
    bit          sink_idle;
    bit          hold_request;

    always #(CLK_HALF) aclk = ~aclk;

    // Run-away guard.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_verdicts.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Work out the verdict for one header and update the table copy.
    function automatic verdict_t limit_header(input header_t h);
        verdict_t    v;
        int          slot;
        logic [63:0] need;
        v = '0;
        slot = -1;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (slot_valid[i] && slot_key[i] == h.msg_type) slot = i;
        end
        // Late headers only report the counts of a known type.
        if (h.msg_time > lim_time) begin
            v.status = ST_TOO_LATE;
            if (slot >= 0) begin
                v.msg_count    = slot_msgs[slot];
                v.second_count = slot_secs[slot];
            end
            return v;
        end
        // An unknown type claims the lowest free slot, if any.
        if (slot < 0) begin
            for (int i = ENTRIES - 1; i >= 0; i--) begin
                if (!slot_valid[i]) slot = i;
            end
            if (slot < 0) begin
                v.status = ST_TAB_FULL;
                return v;
            end
            slot_valid[slot]  = 1'b1;
            slot_key[slot]    = h.msg_type;
            slot_msgs[slot]   = '0;
            slot_secs[slot]   = '0;
            slot_second[slot] = '0;
            slot_bytes[slot]  = '0;
        end
        // A different second restarts the byte budget.
        if (slot_second[slot] != h.msg_time) begin
            slot_second[slot] = h.msg_time;
            if (slot_secs[slot] != '1) slot_secs[slot] = slot_secs[slot] + 32'd1;
            slot_bytes[slot] = '0;
        end
        need = 64'(slot_bytes[slot]) + 64'(h.msg_len) + 64'(lim_header);
        if (need > 64'(lim_buffer)) begin
            v.status = ST_BUF_FULL;
        end else begin
            slot_bytes[slot] = slot_bytes[slot] + h.msg_len[15:0];
            if (slot_msgs[slot] != '1) slot_msgs[slot] = slot_msgs[slot] + 32'd1;
            v.status = ST_ACCEPTED;
        end
        v.msg_count    = slot_msgs[slot];
        v.second_count = slot_secs[slot];
        return v;
    endfunction

    function automatic header_t make_header(input logic [31:0] msg_type,
                                            input logic [31:0] msg_time,
                                            input logic [31:0] msg_len);
        header_t h;
        h.msg_type = msg_type;
        h.msg_time = msg_time;
        h.msg_len  = msg_len;
        return h;
    endfunction

    // A type that is not in the pool of table keys.
    function automatic logic [31:0] unknown_type();
        logic [31:0] key;
        bit          clash;
        do begin
            key = $urandom;
            clash = 1'b0;
            foreach (known_types[i]) begin
                if (known_types[i] == key) clash = 1'b1;
            end
        end while (clash);
        return key;
    endfunction

    // Mostly known types around the current second, with some noise mixed in.
    function automatic header_t random_header();
        header_t     h;
        int          pick;
        logic [31:0] span;
        pick = $urandom_range(0, 99);
        h.msg_type = (pick < 88) ? known_types[$urandom_range(0, ENTRIES - 1)]
                                 : unknown_type();
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            h.msg_time = now_sec;
        end else if (pick < 80) begin
            h.msg_time = (now_sec == lim_time) ? now_sec : now_sec + 32'd1;
        end else if (pick < 90 || lim_time == '1) begin
            h.msg_time = $urandom;
        end else begin
            h.msg_time = $urandom_range(lim_time + 32'd1, 32'hFFFF_FFFF);
        end
        span = {16'h0, lim_buffer};
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            h.msg_len = $urandom_range(0, span / 3 + 1);
        end else if (pick < 95) begin
            h.msg_len = $urandom_range(0, span + 256);
        end else begin
            h.msg_len = $urandom;
        end
        if ($urandom_range(0, 15) == 0 && now_sec < lim_time) now_sec = now_sec + 32'd1;
        return h;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= REPORT_CAP) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
        end
    endtask

    // Offer one header after a random gap and keep it up until it is taken.
    task automatic send_header(input header_t h);
        int gap;
        gap = src_idle ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= h;
        do @(posedge aclk); while (!s_tready);
        pending_verdicts.push_back(limit_header(h));
        sent++;
    endtask

    // Stop offering and let every outstanding result come back.
    task automatic finish_phase();
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Leaves cfg_we high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CfgAddrWidth-1:0] addr,
                             input logic [CfgDataWidth-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        case (addr)
            REG_BUFFER_LIMIT: lim_buffer = value[15:0];
            REG_HEADER_BYTES: lim_header = value[7:0];
            REG_TIME_LIMIT:   lim_time   = value;
            default: ;
        endcase
    endtask

    // Upper bits beyond each register's width carry junk that must be dropped.
    task automatic apply_limits(input logic [15:0] buf_lim, input logic [7:0] hdr,
                                input logic [31:0] tlim);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(REG_UNUSED, $urandom);
        write_reg(REG_BUFFER_LIMIT, {junk[31:16], buf_lim});
        write_reg(REG_HEADER_BYTES, {junk[23:0], hdr});
        write_reg(REG_TIME_LIMIT, tlim);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [15:0] buf_lim, input logic [7:0] hdr,
                             input logic [31:0] tlim, input int count, input bit hold);
        apply_limits(buf_lim, hdr, tlim);
        now_sec = (tlim < 32'd200) ? 32'd0 : $urandom_range(0, tlim - 32'd200);
        for (int i = 0; i < count; i++) begin
            if (i % 64 == 0) begin
                src_idle  = $urandom_range(0, 3) != 0;
                sink_idle = $urandom_range(0, 3) != 0;
            end
            if (hold && i == 8) hold_request = 1'b1;
            send_header(random_header());
        end
        finish_phase();
    endtask

    // Corner cases at the reset limits: 2048 bytes, 16 header bytes, time 100000.
    task automatic test_directed_cases();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        known_types[0] = 32'h0000_0000;
        known_types[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < ENTRIES; i++) known_types[i] = unknown_type();
        // New type at second zero counts no second; then fill exactly to the limit.
        send_header(make_header(known_types[0], 32'd0, 32'd0));
        send_header(make_header(known_types[0], 32'd0, 32'd2032));
        send_header(make_header(known_types[0], 32'd0, 32'd1));
        // Huge length overflows only at full precision; the new second sticks.
        send_header(make_header(known_types[0], 32'd1, 32'hFFFF_FFFF));
        send_header(make_header(known_types[0], 32'd1, 32'd2032));
        // Time exactly at the limit passes, one past it is late.
        send_header(make_header(known_types[1], 32'd100000, 32'd7));
        send_header(make_header(known_types[1], 32'd100001, 32'd0));
        // A late unknown type reports zeros and takes no entry.
        send_header(make_header(unknown_type(), 32'hFFFF_FFFF, 32'd0));
        // A new type dropped for a full buffer still keeps its entry.
        send_header(make_header(known_types[2], 32'd5, 32'hFFFF_FFFF));
        send_header(make_header(known_types[2], 32'd5, 32'd0));
        // Fill the rest of the table, then an unknown type finds it full.
        for (int i = 3; i < ENTRIES; i++) begin
            send_header(make_header(known_types[i], $urandom_range(0, 100000),
                                    $urandom_range(0, 1000)));
        end
        send_header(make_header(unknown_type(), 32'd7, 32'd1));
        finish_phase();
    endtask

    task automatic test_default_traffic();
        run_phase(BUFFER_LIMIT_RESET, HEADER_BYTES_RESET, TIME_LIMIT_RESET, 400, 1'b0);
    endtask

    task automatic test_wide_limits();
        run_phase(16'hFFFF, 8'd0, 32'hFFFF_FFFF, 300, 1'b0);
    endtask

    task automatic test_narrow_limits();
        run_phase(16'd1, 8'd0, 32'd0, 80, 1'b0);
    endtask

    task automatic test_large_header();
        run_phase(16'd600, 8'd255, 32'd1000, 200, 1'b0);
    endtask

    // Buffer limit of zero.
    task automatic test_zero_buffer_limit();
        run_phase(16'd0, 8'd16, 32'd500, 40, 1'b0);
    endtask

    task automatic test_receiver_backpressure();
        run_phase(BUFFER_LIMIT_RESET, HEADER_BYTES_RESET, TIME_LIMIT_RESET, 80, 1'b1);
    endtask

    task automatic test_random_limits();
        logic [15:0] buf_lim;
        logic [7:0]  hdr;
        logic [31:0] tlim;
        for (int p = 0; p < 4; p++) begin
            buf_lim = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                                  : 16'($urandom_range(16, 3000));
            hdr  = 8'($urandom_range(0, 255));
            tlim = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 5000);
            run_phase(buf_lim, hdr, tlim, 170, 1'b0);
        end
    endtask

    // Result receiver: random stalls, and one long hold-off on request.
    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_request) begin
                stall = HOLD_CYCLES;
            end else if (sink_idle) begin
                stall = $urandom_range(0, MAX_WAIT);
            end else begin
                stall = 0;
            end
            hold_request = 1'b0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Compare each delivered result with the oldest outstanding verdict.
    always @(posedge aclk) begin : check_results
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                note_mismatch("unexpected result, count", 32'd0, m_tdata[31:0]);
            end else begin
                want = pending_verdicts.pop_front();
                checked++;
                status_seen[want.status]++;
                if (m_tuser !== want.status) begin
                    note_mismatch("status", 32'(want.status), 32'(m_tuser));
                end
                if (m_tdata[31:0] !== want.msg_count) begin
                    note_mismatch("message count", want.msg_count, m_tdata[31:0]);
                end
                if (m_tdata[63:32] !== want.second_count) begin
                    note_mismatch("second count", want.second_count, m_tdata[63:32]);
                end
            end
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_we       = 1'b0;
        cfg_addr     = REG_BUFFER_LIMIT;
        cfg_wdata    = '0;
        hold_request = 1'b0;
        lim_buffer   = BUFFER_LIMIT_RESET;
        lim_header   = HEADER_BYTES_RESET;
        lim_time     = TIME_LIMIT_RESET;
        foreach (slot_valid[i]) slot_valid[i] = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_default_traffic();
        test_wide_limits();
        test_narrow_limits();
        test_large_header();
        test_zero_buffer_limit();
        test_receiver_backpressure();
        test_random_limits();

        $display("Checked %0d results for %0d headers: %0d accepted, %0d late, %0d over budget,",
                 checked, sent, status_seen[ST_ACCEPTED], status_seen[ST_TOO_LATE],
                 status_seen[ST_BUF_FULL]);
        $display("%0d table full; limits swept between extremes, with a long result stall.",
                 status_seen[ST_TAB_FULL]);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
